// ----- sv/lsb_first_bit_packer_defines.svh -----
// Assertion macros for the bit packer RTL.
// Used by files that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef LSB_FIRST_BIT_PACKER_DEFINES_SVH
`define LSB_FIRST_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define LBP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bit packer same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define LBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bit packer next-cycle check failed");

`endif

// ----- sv/lbp_pkg.sv -----
// Package for the LSB-first bit packer: constants, state type and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int MAX_CODE_WIDTH = 32;
    localparam int CODE_W_BITS    = 6;
    // Seven pending bits plus one full-width code.
    localparam int ACC_W          = MAX_CODE_WIDTH + BYTE_BITS - 1;
    localparam int CNT_W          = 6;

    localparam logic CMD_PACK  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } lbp_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } lbp_cmd_t;

    typedef struct packed {
        logic cnt_ge8;
        logic cnt_lt16;
        logic out_free;
    } lbp_stat_t;

endpackage

`default_nettype wire

// ----- sv/lbp_ctrl.sv -----
// Controller state machine of the bit packer.
// Depends on lbp_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module lbp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lbp_pkg::lbp_stat_t stat,
    output lbp_pkg::lbp_cmd_t      cmd
);

    lbp_pkg::lbp_state_t state_reg;
    lbp_pkg::lbp_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. In the emit state one byte leaves per cycle
    // while the output register is free; the last byte returns to idle, as does a count below a full byte.
    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            lbp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = lbp_pkg::ST_EMIT;
                end
            end
            lbp_pkg::ST_EMIT: begin
                if (!stat.cnt_ge8) begin
                    state_next = lbp_pkg::ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.cnt_lt16) begin
                        state_next = lbp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = lbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/lbp_dp.sv -----
// Datapath of the bit packer: bit accumulator, bit count and output register.
// Depends on lbp_pkg and on lsb_first_bit_packer_defines.svh for assertions.
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_first_bit_packer_defines.svh"

module lbp_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lbp_pkg::lbp_cmd_t                 cmd,
    output lbp_pkg::lbp_stat_t                     stat,
    input  wire logic                              in_flush,
    input  wire logic [lbp_pkg::MAX_CODE_WIDTH-1:0] in_value,
    input  wire logic [lbp_pkg::CODE_W_BITS-1:0]   in_width,
    output logic [lbp_pkg::BYTE_BITS-1:0]          out_byte,
    output logic                                   out_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);

    logic [lbp_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [lbp_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [lbp_pkg::BYTE_BITS-1:0]      byte_reg, byte_next;
    logic                               last_reg, last_next;
    logic                               m_valid_reg, m_valid_next;
    logic [lbp_pkg::CODE_W_BITS-1:0]    width_sat;
    logic [lbp_pkg::MAX_CODE_WIDTH-1:0] code_mask;
    logic [lbp_pkg::ACC_W-1:0]          code_shifted;

    // Saturate the width to 32 and keep only the low code bits.
    always_comb begin
        if (in_width > lbp_pkg::CODE_W_BITS'(lbp_pkg::MAX_CODE_WIDTH)) begin
            width_sat = lbp_pkg::CODE_W_BITS'(lbp_pkg::MAX_CODE_WIDTH);
        end else begin
            width_sat = in_width;
        end
        if (width_sat[lbp_pkg::CODE_W_BITS-1]) begin
            code_mask = '1;
        end else begin
            code_mask = (lbp_pkg::MAX_CODE_WIDTH'(1) << width_sat[lbp_pkg::CODE_W_BITS-2:0])
                        - lbp_pkg::MAX_CODE_WIDTH'(1);
        end
        code_shifted = lbp_pkg::ACC_W'(in_value & code_mask) << cnt_reg[2:0];
    end

    // Status for the controller.
    always_comb begin
        stat.cnt_ge8  = (cnt_reg >= lbp_pkg::CNT_W'(lbp_pkg::BYTE_BITS));
        stat.cnt_lt16 = (cnt_reg < lbp_pkg::CNT_W'(2 * lbp_pkg::BYTE_BITS));
        stat.out_free = !m_valid_reg || out_ready;
    end

    // Accumulator update. A flush with bits pending pads the count up to a
    // full byte; the bits above the count are always zero.
    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            if (in_flush) begin
                cnt_next = (cnt_reg != '0) ? lbp_pkg::CNT_W'(lbp_pkg::BYTE_BITS) : '0;
            end else begin
                acc_next = acc_reg | code_shifted;
                cnt_next = cnt_reg + width_sat;
            end
        end else if (cmd.emit) begin
            acc_next = acc_reg >> lbp_pkg::BYTE_BITS;
            cnt_next = cnt_reg - lbp_pkg::CNT_W'(lbp_pkg::BYTE_BITS);
        end
    end

    // Output register with its valid flag.
    always_comb begin
        byte_next    = byte_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            byte_next    = acc_reg[lbp_pkg::BYTE_BITS-1:0];
            last_next    = stat.cnt_lt16;
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_valid = m_valid_reg;

    // Checks on the command/status interplay and the accumulator invariant.
    `LBP_ASSERT_IMPLY(a_emit_ok, cmd.emit, stat.cnt_ge8 && stat.out_free)
    `LBP_ASSERT_IMPLY(a_load_idle, cmd.load, !stat.cnt_ge8 && !cmd.emit)
    `LBP_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_reg <= lbp_pkg::CNT_W'(lbp_pkg::ACC_W))
    `LBP_ASSERT_IMPLY(a_acc_clean, 1'b1, (acc_reg >> cnt_reg) == '0)
    `LBP_ASSERT_NEXT(a_emit_valid, cmd.emit, m_valid_reg)

endmodule

`default_nettype wire

// ----- sv/lsb_first_bit_packer.sv -----
// LSB-first bit packer for 0..32-bit codes: usage notes
//
// Input channel (s_): tdata carries code_value and code_width, tuser carries
// the command (0 = pack, 1 = flush). Output channel (m_): tdata carries one
// packed byte, earlier bits in lower positions; tlast marks the final byte
// caused by an input item. Items that cause no byte produce no output.
// An item is accepted into the accumulator; the block then emits one byte per
// cycle into the output register while the output register is free, the pace
// set by the single byte-wide output path. The first byte of an item passes
// from the accumulator into the output register, which drives m_tdata.
// A new item is accepted while the last byte of the previous one still
// waits in the output register.
// When the receiver stalls, the pending byte holds and emission pauses;
// s_tready stays low until the item's bytes have entered the output register.
// Reset (aresetn low, synchronous) clears the pending bits and count and
// empties the output register.
// Depends on lbp_pkg, lbp_ctrl and lbp_dp.
`timescale 1ns / 1ps
`default_nettype none

module lsb_first_bit_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] code_value, [37:32] code_width, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);

    lbp_pkg::lbp_cmd_t  cmd;
    lbp_pkg::lbp_stat_t stat;

    // Sequencer: accepts items and paces byte emission.
    lbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Accumulator and output register.
    lbp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_flush  (s_tuser[0] == lbp_pkg::CMD_FLUSH),
        .in_value  (s_tdata[31:0]),
        .in_width  (s_tdata[37:32]),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule

`default_nettype wire
